### design/iatp_pkg.sv
// Package: character codes, parser state type and helper functions for the address parser
`default_nettype none
package iatp_pkg;

  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChOpenBr  = 8'h5b;
  localparam logic [3:0] NameLen   = 4'd9;
  localparam logic [3:0] NameMiss  = 4'd15;

  typedef struct packed {
    logic [3:0]       char_pos;
    logic [7:0]       prev_char;
    logic [3:0]       v6_pos;
    logic [3:0][7:0]  plain_octets;
    logic [1:0]       plain_dots;
    logic             plain_failed;
    logic [3:0]       name_match;
    logic [3:0][7:0]  mapped_octets;
    logic [1:0]       mapped_dots;
    logic             mapped_failed;
    logic             mapped_last_dot;
    logic             bracketed;
    logic [15:0][7:0] v6_bytes;
    logic [15:0]      group_value;
    logic [2:0]       group_digits;
    logic [4:0]       byte_index;
    logic [4:0]       gap_index;
    logic             gap_valid;
    logic [1:0]       colon_run;
    logic [8:0]       scope_value;
    logic             scope_mode;
    logic             scope_seen;
    logic             v6_failed;
  } parse_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h6c;
      4'd1: r = 8'h6f;
      4'd2: r = 8'h63;
      4'd3: r = 8'h61;
      4'd4: r = 8'h6c;
      4'd5: r = 8'h68;
      4'd6: r = 8'h6f;
      4'd7: r = 8'h73;
      4'd8: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/iatp_if.sv
// Interfaces: valid/ready channels for characters and parse results
`default_nettype none
interface iatp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;
  logic       empty_string;
  modport source (output valid, char_code, last, empty_string, input ready);
  modport sink (input valid, char_code, last, empty_string, output ready);
endinterface

interface iatp_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        is_v6;
  logic [63:0] addr_upper;
  logic [63:0] addr_lower;
  logic [7:0]  scope;
  modport source (output valid, ok, is_v6, addr_upper, addr_lower, scope, input ready);
  modport sink (input valid, ok, is_v6, addr_upper, addr_lower, scope, output ready);
endinterface
`default_nettype wire

### design/iatp_step.sv
// Step logic: parser state update for one character
`default_nettype none
module iatp_step (
  input  var iatp_pkg::parse_state_t cur,
  input  var logic [7:0]             c,
  output iatp_pkg::parse_state_t     nxt
);
  import iatp_pkg::*;

  function automatic void v4_feed(inout logic [3:0][7:0] oct, inout logic [1:0] dots,
                                  inout logic failed, input logic first,
                                  input logic prev_dot, input logic [7:0] ch);
    logic [11:0] v;
    v = 12'(oct[2'd3 - dots]) * 12'd10 + 12'(ch - 8'h30);
    if (!failed) begin
      if (is_digit(ch)) begin
        if (v > 12'd255) failed = 1'b1;
        else oct[2'd3 - dots] = v[7:0];
      end else if (ch == ChDot) begin
        if (dots == 2'd3 || first || prev_dot) failed = 1'b1;
        else dots = dots + 2'd1;
      end else begin
        failed = 1'b1;
      end
    end
  endfunction

  function automatic void v6_feed(inout parse_state_t s, input logic [7:0] ch);
    logic [3:0]  i;
    logic        hv;
    logic [3:0]  h;
    logic [12:0] sv;
    logic [4:0]  bi;
    i  = s.v6_pos;
    hv = 1'b1;
    h  = 4'd0;
    if (is_digit(ch)) h = ch[3:0];
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      h = ch[3:0] + 4'd9;
    else hv = 1'b0;
    if (!s.mapped_failed) begin
      if (i < 4'd2 || i == 4'd6) begin
        if (ch != ChColon) s.mapped_failed = 1'b1;
      end else if (i < 4'd6) begin
        if (ch != 8'h66 && ch != 8'h46) s.mapped_failed = 1'b1;
      end else begin
        v4_feed(s.mapped_octets, s.mapped_dots, s.mapped_failed, i == 4'd7,
                s.mapped_last_dot, ch);
        s.mapped_last_dot = (ch == ChDot);
      end
    end
    if (!s.v6_failed) begin
      if (s.scope_mode) begin
        sv = 13'(s.scope_value) * 13'd10 + 13'(ch - 8'h30);
        if (is_digit(ch) && sv <= 13'd255) begin
          s.scope_value = sv[8:0];
          s.scope_seen  = 1'b1;
        end else begin
          s.v6_failed = 1'b1;
        end
      end else if (hv) begin
        if (s.group_digits >= 3'd4) begin
          s.v6_failed = 1'b1;
        end else begin
          s.group_value  = {s.group_value[11:0], h};
          s.group_digits = s.group_digits + 3'd1;
          s.v6_bytes[15 - s.byte_index[3:0]] = s.group_value[15:8];
          s.v6_bytes[15 - 4'(s.byte_index[3:0] + 4'd1)] = s.group_value[7:0];
          s.colon_run = 2'd0;
        end
      end else if (ch == ChColon) begin
        s.group_value  = 16'd0;
        s.group_digits = 3'd0;
        if (s.colon_run >= 2'd1) begin
          if (s.colon_run >= 2'd2 || s.gap_valid) s.v6_failed = 1'b1;
          s.gap_index = s.byte_index;
          s.gap_valid = 1'b1;
        end else if (i > 4'd0) begin
          s.byte_index = s.byte_index + 5'd2;
        end
        bi = s.byte_index;
        if (bi > 5'd14) begin
          s.v6_failed = 1'b1;
        end else if (!s.v6_failed) begin
          s.v6_bytes[15 - bi[3:0]] = 8'd0;
          s.v6_bytes[14 - bi[3:0]] = 8'd0;
        end
        if (s.colon_run < 2'd2) s.colon_run = s.colon_run + 2'd1;
      end else if (ch == ChPercent) begin
        s.scope_mode = 1'b1;
        s.colon_run  = 2'd0;
      end else begin
        s.v6_failed = 1'b1;
      end
    end
    if (s.v6_pos < 4'd15) s.v6_pos = s.v6_pos + 4'd1;
  endfunction

  always_comb begin
    logic [7:0] low;
    nxt = cur;
    low = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    if (cur.char_pos < NameLen && cur.name_match == cur.char_pos
        && low == name_char(cur.char_pos))
      nxt.name_match = cur.name_match + 4'd1;
    else
      nxt.name_match = NameMiss;
    v4_feed(nxt.plain_octets, nxt.plain_dots, nxt.plain_failed, cur.char_pos == 4'd0,
            cur.char_pos != 4'd0 && cur.prev_char == ChDot, c);
    if (cur.char_pos == 4'd0 && c == ChOpenBr) begin
      nxt.bracketed = 1'b1;
    end else if (cur.bracketed) begin
      if (cur.char_pos >= 4'd2) v6_feed(nxt, cur.prev_char);
    end else begin
      v6_feed(nxt, c);
    end
    nxt.prev_char = c;
    if (cur.char_pos < 4'd15) nxt.char_pos = cur.char_pos + 4'd1;
  end

endmodule
`default_nettype wire

### design/ip_address_text_parser.sv
// Top level: streaming IPv4/IPv6 address text parser
//   channel  | dir | beat
//   in_ch    | in  | char_code, last, empty_string
//   out_ch   | out | ok, is_v6, addr_upper, addr_lower, scope
// One character beat per cycle; parser state updates in the same cycle.
// A final beat registers the decoded address in the result register,
// which is offered on out_ch the next cycle. Input stalls only while that register is
// full and not taken. Reset (rst, synchronous) clears parser state.
`default_nettype none
module ip_address_text_parser (
  input  var logic clk,
  input  var logic rst,
  iatp_in_if.sink    in_ch,
  iatp_out_if.source out_ch
);
  import iatp_pkg::*;

  parse_state_t st, st_next, fin;
  logic         acc, ends;
  logic [15:0][7:0] b;
  logic         f_ok, f_v6;
  logic [7:0]   f_scope;
  logic [4:0]   sh;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign acc  = in_ch.valid && in_ch.ready;
  assign ends = in_ch.last || in_ch.empty_string;

  iatp_step u_step (.cur(st), .c(in_ch.char_code), .nxt(st_next));

  assign fin = in_ch.empty_string ? st : st_next;

  always_comb begin
    f_ok = 1'b0;
    f_v6 = 1'b0;
    f_scope = 8'd0;
    b = '0;
    sh = 5'd14 - fin.byte_index;
    if (fin.char_pos == 4'd0) begin
      f_ok = 1'b1;
    end else if (fin.name_match == NameLen) begin
      f_ok = 1'b1;
      b[15] = 8'd127;
      b[12] = 8'd1;
    end else if (!fin.plain_failed && fin.plain_dots == 2'd3 && fin.prev_char != ChDot) begin
      f_ok = 1'b1;
      b[15:12] = fin.plain_octets;
    end else if (!(fin.bracketed && fin.char_pos < 4'd3)) begin
      if (!fin.mapped_failed && fin.v6_pos >= 4'd14 && fin.mapped_dots == 2'd3
          && !fin.mapped_last_dot) begin
        f_ok = 1'b1;
        f_v6 = 1'b1;
        b[5] = 8'hff;
        b[4] = 8'hff;
        b[3:0] = fin.mapped_octets;
      end else if (!fin.v6_failed && !(fin.scope_mode && !fin.scope_seen)
                   && !(fin.byte_index < 5'd14 && !fin.gap_valid)) begin
        f_ok = 1'b1;
        f_v6 = 1'b1;
        f_scope = fin.scope_value[7:0];
        for (int k = 0; k < 16; k++) begin
          if (fin.byte_index < 5'd14 && fin.gap_index <= fin.byte_index) begin
            if (5'(k) < fin.gap_index) b[15-k] = fin.v6_bytes[15-k];
            else if (5'(k) < fin.gap_index + sh) b[15-k] = 8'd0;
            else b[15-k] = fin.v6_bytes[15 - 4'(5'(k) - sh)];
          end else begin
            b[15-k] = fin.v6_bytes[15-k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.ready) out_ch.valid <= 1'b0;
      if (acc) begin
        st <= ends ? '0 : st_next;
        if (ends) out_ch.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && ends) begin
      out_ch.ok         <= f_ok;
      out_ch.is_v6      <= f_v6;
      out_ch.addr_upper <= b[15:8];
      out_ch.addr_lower <= b[7:0];
      out_ch.scope      <= f_scope;
    end
  end

endmodule
`default_nettype wire

### tb/sv/ip_address_text_parser_checker.sv
// Checker: predicts parse results from accepted character beats and compares them
`default_nettype none
module ip_address_text_parser_checker (
  input  var logic clk,
  input  var logic rst,
  iatp_in_if         in_mon,
  iatp_out_if        out_mon,
  output int         fail_count,
  output int         pending_count
);
  import iatp_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        is_v6;
    logic [63:0] addr_upper;
    logic [63:0] addr_lower;
    logic [7:0]  scope;
  } addr_result_t;

  parse_state_t st;
  addr_result_t expected_addrs[$];

  assign pending_count = expected_addrs.size();

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic quad_feed(inout logic [3:0][7:0] oct, inout logic [1:0] dots,
                           inout logic failed, input logic first, input logic prev_dot,
                           input logic [7:0] c);
    int v;
    if (failed) return;
    if (c >= "0" && c <= "9") begin
      v = oct[3 - dots] * 10 + (c - "0");
      if (v > 255) failed = 1;
      else oct[3 - dots] = v[7:0];
    end else if (c == ChDot) begin
      if (dots == 3 || first || prev_dot) failed = 1;
      else dots++;
    end else begin
      failed = 1;
    end
  endtask

  task automatic hex_feed(input logic [7:0] c);
    logic [3:0] i;
    int h;
    int v;
    i = st.v6_pos;
    if (!st.mapped_failed) begin
      if (i < 2 || i == 6) begin
        if (c != ChColon) st.mapped_failed = 1;
      end else if (i < 6) begin
        if (c != "f" && c != "F") st.mapped_failed = 1;
      end else begin
        quad_feed(st.mapped_octets, st.mapped_dots, st.mapped_failed, i == 7,
                  st.mapped_last_dot, c);
        st.mapped_last_dot = (c == ChDot);
      end
    end
    if (!st.v6_failed) begin
      h = hex_digit(c);
      if (st.scope_mode) begin
        if (c >= "0" && c <= "9") begin
          v = st.scope_value * 10 + (c - "0");
          st.scope_value = v[8:0];
          st.scope_seen = 1;
          if (v[15:0] > 255) st.v6_failed = 1;
        end else begin
          st.v6_failed = 1;
        end
      end else if (h >= 0) begin
        if (st.group_digits >= 4) begin
          st.v6_failed = 1;
        end else begin
          st.group_value = {st.group_value[11:0], h[3:0]};
          st.group_digits++;
          st.v6_bytes[15 - st.byte_index[3:0]] = st.group_value[15:8];
          st.v6_bytes[15 - 4'(st.byte_index[3:0] + 1)] = st.group_value[7:0];
          st.colon_run = 0;
        end
      end else if (c == ChColon) begin
        st.group_value = 0;
        st.group_digits = 0;
        if (st.colon_run >= 1) begin
          if (st.colon_run >= 2 || st.gap_valid) st.v6_failed = 1;
          st.gap_index = st.byte_index;
          st.gap_valid = 1;
        end else if (i > 0) begin
          st.byte_index = st.byte_index + 2;
        end
        if (st.byte_index > 14) begin
          st.v6_failed = 1;
        end else if (!st.v6_failed) begin
          st.v6_bytes[15 - st.byte_index] = 0;
          st.v6_bytes[14 - st.byte_index] = 0;
        end
        if (st.colon_run < 2) st.colon_run++;
      end else if (c == ChPercent) begin
        st.scope_mode = 1;
        st.colon_run = 0;
      end else begin
        st.v6_failed = 1;
      end
    end
    if (st.v6_pos < 15) st.v6_pos++;
  endtask

  function automatic addr_result_t decode_addr(input parse_state_t s);
    addr_result_t r;
    logic [7:0] b[16];
    logic [7:0] t[16];
    int sh;
    r = '0;
    for (int k = 0; k < 16; k++) b[k] = 0;
    if (s.char_pos == 0) begin
      r.ok = 1;
    end else if (s.name_match == NameLen) begin
      r.ok = 1;
      b[0] = 127;
      b[3] = 1;
    end else if (!s.plain_failed && s.plain_dots == 3 && s.prev_char != ChDot) begin
      r.ok = 1;
      for (int k = 0; k < 4; k++) b[k] = s.plain_octets[3 - k];
    end else if (!(s.bracketed && s.char_pos < 3)) begin
      if (!s.mapped_failed && s.v6_pos >= 14 && s.mapped_dots == 3 &&
          !s.mapped_last_dot) begin
        r.ok = 1;
        r.is_v6 = 1;
        b[10] = 255;
        b[11] = 255;
        for (int k = 0; k < 4; k++) b[12 + k] = s.mapped_octets[3 - k];
      end else if (!s.v6_failed && !(s.scope_mode && !s.scope_seen) &&
                   !(s.byte_index < 14 && !s.gap_valid)) begin
        r.ok = 1;
        r.is_v6 = 1;
        r.scope = s.scope_value[7:0];
        for (int k = 0; k < 16; k++) b[k] = s.v6_bytes[15 - k];
        if (s.byte_index < 14 && s.gap_index <= s.byte_index) begin
          sh = 14 - s.byte_index;
          t = b;
          for (int k = s.gap_index; k < s.byte_index + 2; k++) b[k + sh] = t[k];
          for (int k = s.gap_index; k < s.gap_index + sh; k++) b[k] = 0;
        end
      end
    end
    for (int k = 0; k < 8; k++) begin
      r.addr_upper = {r.addr_upper[55:0], b[k]};
      r.addr_lower = {r.addr_lower[55:0], b[k + 8]};
    end
    return r;
  endfunction

  function automatic parse_state_t idle_state();
    parse_state_t s;
    s = '0;
    return s;
  endfunction

  task automatic take_char(input logic [7:0] c, input logic fin, input logic empty);
    logic [7:0] low;
    if (!empty) begin
      low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (st.char_pos < NameLen && st.name_match == st.char_pos &&
          low == name_char(st.char_pos))
        st.name_match++;
      else
        st.name_match = NameMiss;
      quad_feed(st.plain_octets, st.plain_dots, st.plain_failed, st.char_pos == 0,
                st.char_pos > 0 && st.prev_char == ChDot, c);
      if (st.char_pos == 0 && c == ChOpenBr) st.bracketed = 1;
      else if (st.bracketed) begin
        if (st.char_pos >= 2) hex_feed(st.prev_char);
      end else hex_feed(c);
      st.prev_char = c;
      if (st.char_pos < 15) st.char_pos++;
    end
    if (empty || fin) begin
      expected_addrs.push_back(decode_addr(st));
      st = idle_state();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  addr_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      st <= idle_state();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.ok, out_mon.is_v6, out_mon.addr_upper, out_mon.addr_lower,
                out_mon.scope};
        if (expected_addrs.size() == 0) begin
          report_mismatch("unexpected beat", got.addr_upper, 0);
        end else begin
          want = expected_addrs.pop_front();
          if (got.ok != want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.is_v6 != want.is_v6) report_mismatch("is_v6", got.is_v6, want.is_v6);
          if (got.addr_upper != want.addr_upper)
            report_mismatch("addr_upper", got.addr_upper, want.addr_upper);
          if (got.addr_lower != want.addr_lower)
            report_mismatch("addr_lower", got.addr_lower, want.addr_lower);
          if (got.scope != want.scope) report_mismatch("scope", got.scope, want.scope);
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_char(in_mon.char_code, in_mon.last, in_mon.empty_string);
    end
  end
endmodule
`default_nettype wire

### tb/sv/ip_address_text_parser_tb.sv
// Testbench top: drives address strings, stalls the result side, gives the verdict
`default_nettype none
module ip_address_text_parser_tb;
  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending_count;
  int   idle_cycles = 0;
  int   hold_cycles = 0;
  int   sent = 0;
  logic stim_done = 0;

  iatp_in_if  in_ch();
  iatp_out_if out_ch();

  ip_address_text_parser u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));
  ip_address_text_parser_checker u_chk (.clk(clk), .rst(rst), .in_mon(in_ch),
    .out_mon(out_ch), .fail_count(fail_count), .pending_count(pending_count));

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.char_code = 0;
    in_ch.last = 0;
    in_ch.empty_string = 0;
    out_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
  end

  task automatic send_beat(input logic [7:0] c, input logic fin, input logic empty);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.char_code <= c;
    in_ch.last <= fin;
    in_ch.empty_string <= empty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    if (s.len() == 0)
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], k == s.len() - 1, 1'b0);
  endtask

  function automatic string hex_group();
    string g;
    string d;
    d = "0123456789abcdefABCDEF";
    g = "";
    for (int k = $urandom_range(1, 4); k > 0; k--) g = {g, string'(d[$urandom_range(0, 21)])};
    return g;
  endfunction

  function automatic string octet_text();
    string o;
    o.itoa($urandom_range(0, 3) == 0 ? $urandom_range(250, 300) : $urandom_range(0, 255));
    return o;
  endfunction

  function automatic string random_addr();
    string s;
    string t;
    int n;
    int gap;
    case ($urandom_range(0, 7))
      0: s = {octet_text(), ".", octet_text(), ".", octet_text(), ".", octet_text()};
      1: s = {"::", $urandom_range(0, 1) ? "ffff" : "FfFf", ":", octet_text(), ".",
              octet_text(), ".", octet_text(), ".", octet_text()};
      2, 3, 4: begin
        n = $urandom_range(1, 8);
        gap = $urandom_range(0, 2) ? $urandom_range(0, n) : -1;
        s = "";
        for (int k = 0; k < n; k++) begin
          if (k == gap) s = {s, "::"};
          else if (k > 0) s = {s, ":"};
          s = {s, hex_group()};
        end
        if (gap == n) s = {s, "::"};
        if ($urandom_range(0, 3) == 0) begin
          t.itoa($urandom_range(0, 300));
          s = {s, "%", t};
        end
        if ($urandom_range(0, 2) == 0) s = {"[", s, "]"};
      end
      5: s = $urandom_range(0, 1) ? "LocalHost" : "localhosT";
      6: s = "";
      default: begin
        s = "";
        for (int k = $urandom_range(1, 16); k > 0; k--)
          s = {s, string'(byte'($urandom_range(0, 255)))};
      end
    endcase
    if (s.len() > 0 && $urandom_range(0, 9) == 0) s[$urandom_range(0, s.len() - 1)] =
        byte'($urandom_range(0, 255));
    return s;
  endfunction

  initial begin
    string directed[$];
    directed = '{"", "localhost", "LOCALHOST", "0.0.0.0", "255.255.255.255", "256.1.1.1",
                 "1..2.3", "1.2.3.", "::", "::ffff:10.0.0.1", "::FFFF:1.2.3.4",
                 "1:2:3:4:5:6:7:8", "1:2:3:4:5:6:7:8:9", "12345::", "1::2::3", ":::",
                 "fe80::1%7", "fe80::1%", "::1%256", "1::%9", ":1::", "1:2:3:4:5:6:7:",
                 "[::1]", "[]", "\x80\xff"};
    @(negedge rst);
    @(posedge clk);
    foreach (directed[k]) send_text(directed[k]);
    send_beat("1", 0, 0);
    send_beat(0, 0, 1);
    while (sent < 1350) send_text(random_addr());
    in_ch.valid <= 0;
    stim_done <= 1;
  end

  initial begin
    int d;
    @(negedge rst);
    repeat (40) begin
      d = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
      out_ch.ready <= 0;
      repeat (d) @(posedge clk);
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
    out_ch.ready <= 0;
    hold_cycles = 0;
    while (hold_cycles < 300) begin
      @(posedge clk);
      hold_cycles++;
    end
    out_ch.ready <= 1;
    forever begin
      d = $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
      if (d > 0) begin
        out_ch.ready <= 0;
        repeat (d) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("ip_address_text_parser_tb: errors");
      $finish;
    end
  end

  initial begin
    @(posedge stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ip_address_text_parser_tb: clean");
    end else begin
      $display("ip_address_text_parser_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
design/iatp_pkg.sv
design/iatp_if.sv
design/iatp_step.sv
design/ip_address_text_parser.sv
tb/sv/ip_address_text_parser_checker.sv
tb/sv/ip_address_text_parser_tb.sv
